// File: hw/rtl/slice_triangle_mesh_plane_macros.svh
// assertion macros for the slice_triangle_mesh_plane checker
// expects signals named clk and rst in the scope of use
`ifndef SLICE_TRIANGLE_MESH_PLANE_MACROS_SVH
`define SLICE_TRIANGLE_MESH_PLANE_MACROS_SVH

// same-cycle implication, disabled in reset
`define STMP_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled in reset
`define STMP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/stmp_pkg.sv
// shared types and constants for the triangle mesh plane slicer
// no dependencies
`default_nettype none

package stmp_pkg;

  localparam int EDGE_DEPTH_DEF = 32;

  typedef struct packed {
    logic signed [31:0] normal_x;
    logic signed [31:0] normal_y;
    logic signed [31:0] first_x;
    logic signed [31:0] first_y;
    logic signed [31:0] first_z;
    logic signed [31:0] second_x;
    logic signed [31:0] second_y;
    logic signed [31:0] second_z;
    logic signed [31:0] third_x;
    logic signed [31:0] third_y;
    logic signed [31:0] third_z;
    logic               last_triangle;
  } facet_t;

  typedef struct packed {
    logic signed [31:0] start_x;
    logic signed [31:0] start_y;
    logic signed [31:0] end_x;
    logic signed [31:0] end_y;
    logic               reversed;
    logic               in_plane_edge;
    logic               store_overflow;
    logic               last_segment;
  } seg_t;

  // one stored in-plane edge
  typedef struct packed {
    logic signed [31:0] sx;
    logic signed [31:0] sy;
    logic signed [31:0] ex;
    logic signed [31:0] ey;
    logic               rev;
  } edge_t;

  // crossing point sources, in priority order
  typedef enum logic [2:0] {
    SRC_E01 = 3'd0,
    SRC_E02 = 3'd1,
    SRC_E21 = 3'd2,
    SRC_V0  = 3'd3,
    SRC_V1  = 3'd4,
    SRC_V2  = 3'd5
  } src_t;

  typedef enum logic [1:0] {
    OP_INTERP,
    OP_DIR_A,
    OP_DIR_B
  } op_t;

  typedef enum logic [1:0] {
    U_IDLE,
    U_MUL,
    U_DIV
  } unit_state_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_CLASS,
    S_PT_START,
    S_PT_WAIT,
    S_PT_WR,
    S_DIR_A,
    S_DIR_A_WAIT,
    S_DIR_B,
    S_DIR_B_WAIT,
    S_BRANCH,
    S_PRODUCE,
    S_SCAN_RD,
    S_SCAN_CMP,
    S_SCAN_END,
    S_FINISH,
    S_FL_RD,
    S_FL_CHK,
    S_DRAIN
  } ctrl_state_t;

  typedef struct packed {
    logic take;
    logic load_edge;
    logic unit_start;
    op_t  unit_op;
    logic slot;
    logic axis;
    logic write_pt;
    logic latch_a;
    logic latch_rev;
    logic idx_clear;
    logic idx_inc;
    logic mem_rd;
    logic scan_cmp;
    logic append;
    logic produce;
    logic produce_stored;
    logic push_last;
    logic clear_slice;
  } stmp_cmd_t;

  typedef struct packed {
    logic is_cross;
    logic is_edge;
    logic pt_vertex;
    logic unit_done;
    logic idx_lt_count;
    logic rd_cancelled;
    logic produce_ok;
    logic hold_valid;
    logic out_free;
    logic last_tri;
  } stmp_status_t;

endpackage

`default_nettype wire

// File: hw/rtl/stmp_muldiv.sv
// bit-serial unsigned multiply, optionally followed by restoring divide
// depends on stmp_pkg
`default_nettype none

module stmp_muldiv (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic        div_en,
  input  wire logic [32:0] a,
  input  wire logic [32:0] b,
  input  wire logic [32:0] d,
  output logic             done,
  output logic [65:0]      prod,
  output logic [32:0]      quot
);
  import stmp_pkg::*;

  unit_state_t state, state_next;
  logic [6:0]  cnt;
  logic [65:0] acc;
  logic [65:0] mcand;
  logic [32:0] mplier;
  logic [32:0] dvs;
  logic [32:0] rem;
  logic        div_en_r;
  logic        finish;
  logic [33:0] shifted;
  logic [33:0] diff;
  logic        qbit;

  always_comb begin
    state_next = state;
    case (state)
      U_IDLE: if (start) state_next = U_MUL;
      U_MUL:  if (cnt == 7'd32) state_next = div_en_r ? U_DIV : U_IDLE;
      U_DIV:  if (cnt == 7'd65) state_next = U_IDLE;
      default: state_next = U_IDLE;
    endcase
  end

  always_comb begin
    case (state)
      U_MUL:   finish = (cnt == 7'd32) && !div_en_r;
      U_DIV:   finish = (cnt == 7'd65);
      default: finish = 1'b0;
    endcase
  end

  // restoring divide step, product shifts out of acc, quotient shifts in
  assign shifted = {rem, acc[65]};
  assign diff    = shifted - {1'b0, dvs};
  assign qbit    = !diff[33];

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= U_IDLE;
      done  <= 1'b0;
      cnt   <= '0;
    end else begin
      state <= state_next;
      done  <= finish;
      case (state)
        U_IDLE: cnt <= '0;
        U_MUL:  cnt <= (cnt == 7'd32) ? 7'd0 : cnt + 7'd1;
        U_DIV:  cnt <= cnt + 7'd1;
        default: cnt <= '0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      U_IDLE: begin
        if (start) begin
          acc      <= '0;
          mcand    <= {33'd0, a};
          mplier   <= b;
          dvs      <= d;
          rem      <= '0;
          div_en_r <= div_en;
        end
      end
      U_MUL: begin
        if (mplier[0]) acc <= acc + mcand;
        mcand  <= {mcand[64:0], 1'b0};
        mplier <= {1'b0, mplier[32:1]};
      end
      U_DIV: begin
        rem <= qbit ? diff[32:0] : shifted[32:0];
        acc <= {acc[64:0], qbit};
      end
      default: ;
    endcase
  end

  assign prod = acc;
  assign quot = acc[32:0];

endmodule

`default_nettype wire

// File: hw/rtl/stmp_datapath.sv
// datapath: triangle registers, crossing points, direction, edge store,
// result hold and output registers; depends on stmp_pkg and stmp_muldiv
`default_nettype none

module stmp_datapath #(
  parameter int EDGE_DEPTH = stmp_pkg::EDGE_DEPTH_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 slice_height_we,
  input  wire logic signed [31:0]   slice_height_data,
  input  wire stmp_pkg::facet_t     facet,
  output stmp_pkg::seg_t            seg,
  output logic                      seg_valid,
  input  wire logic                 seg_stall,
  input  wire stmp_pkg::stmp_cmd_t  cmd,
  output stmp_pkg::stmp_status_t    status
);
  import stmp_pkg::*;

  localparam int AW = $clog2(EDGE_DEPTH);
  localparam int CW = $clog2(EDGE_DEPTH + 1);

  logic signed [31:0] height;
  facet_t             facet_r;
  logic signed [31:0] vx [3];
  logic signed [31:0] vy [3];
  logic signed [31:0] vz [3];
  logic [2:0]         gt, lt, eq;
  logic               flat, ge, le;
  logic               c0, c1, c2;
  logic [5:0]         flags;
  src_t               src0, src1, cur_src;
  logic [1:0]         pi, qi, vi;
  logic               is_v;

  logic signed [31:0] xa, xb, za, zb;
  logic signed [32:0] num, den, dxi;
  logic signed [32:0] dyp, dxp;
  logic signed [32:0] nxe, nye;
  logic [32:0]        u_a, u_b, u_d;
  logic               u_done;
  logic [65:0]        u_prod;
  logic [32:0]        u_quot;
  logic signed [33:0] interp_sum;
  logic signed [31:0] pt_val;
  logic               sign_a, sign_b;
  logic signed [66:0] prod_a, prod_b_s;

  logic signed [31:0] px [2];
  logic signed [31:0] py [2];
  logic               rev;

  edge_t              mem_entry [EDGE_DEPTH];
  logic               mem_cancel [EDGE_DEPTH];
  edge_t              rd_entry;
  logic               rd_cancel;
  logic [CW-1:0]      count;
  logic [CW-1:0]      idx;
  logic               found;
  logic               ovf;
  logic               full;
  logic               match;
  logic               cancel_we;
  logic [AW-1:0]      cancel_addr;
  logic               do_append;

  seg_t               hold;
  logic               hold_valid;
  seg_t               new_seg;
  seg_t               push_data;
  logic               out_free;
  logic               push;

  function automatic logic [32:0] mag33(input logic signed [32:0] v);
    mag33 = v[32] ? 33'(-v) : 33'(v);
  endfunction

  // vertex views
  always_comb begin
    vx[0] = facet_r.first_x;  vy[0] = facet_r.first_y;  vz[0] = facet_r.first_z;
    vx[1] = facet_r.second_x; vy[1] = facet_r.second_y; vz[1] = facet_r.second_z;
    vx[2] = facet_r.third_x;  vy[2] = facet_r.third_y;  vz[2] = facet_r.third_z;
  end

  // classification against the plane
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      gt[i] = vz[i] > height;
      lt[i] = vz[i] < height;
      eq[i] = vz[i] == height;
    end
    flat = &eq;
    ge   = ~|lt;
    le   = ~|gt;
    c0   = eq[0] && eq[1] && gt[2];
    c1   = eq[0] && eq[2] && gt[1];
    c2   = eq[2] && eq[1] && gt[0];
    flags[0] = (lt[0] && gt[1]) || (gt[0] && lt[1]);
    flags[1] = (lt[0] && gt[2]) || (gt[0] && lt[2]);
    flags[2] = (lt[2] && gt[1]) || (gt[2] && lt[1]);
    flags[3] = eq[0] && ((lt[1] && gt[2]) || (gt[1] && lt[2]));
    flags[4] = eq[1] && ((lt[2] && gt[0]) || (gt[2] && lt[0]));
    flags[5] = eq[2] && ((lt[0] && gt[1]) || (gt[0] && lt[1]));
  end

  // first two point sources in priority order
  always_comb begin
    logic [1:0] got;
    got  = 2'd0;
    src0 = SRC_E01;
    src1 = SRC_E02;
    for (int i = 0; i < 6; i++) begin
      if (flags[i] && got == 2'd0) begin
        src0 = src_t'(3'(i));
        got  = 2'd1;
      end else if (flags[i] && got == 2'd1) begin
        src1 = src_t'(3'(i));
        got  = 2'd2;
      end
    end
  end

  always_comb begin
    cur_src = cmd.slot ? src1 : src0;
    pi   = 2'd0;
    qi   = 2'd1;
    vi   = 2'd0;
    is_v = 1'b0;
    case (cur_src)
      SRC_E01: begin pi = 2'd0; qi = 2'd1; end
      SRC_E02: begin pi = 2'd0; qi = 2'd2; end
      SRC_E21: begin pi = 2'd2; qi = 2'd1; end
      SRC_V0:  begin is_v = 1'b1; vi = 2'd0; end
      SRC_V1:  begin is_v = 1'b1; vi = 2'd1; end
      SRC_V2:  begin is_v = 1'b1; vi = 2'd2; end
      default: ;
    endcase
  end

  // interpolation and direction operands
  always_comb begin
    xa  = cmd.axis ? vy[pi] : vx[pi];
    xb  = cmd.axis ? vy[qi] : vx[qi];
    za  = vz[pi];
    zb  = vz[qi];
    num = $signed({height[31], height}) - $signed({za[31], za});
    den = $signed({zb[31], zb}) - $signed({za[31], za});
    dxi = $signed({xb[31], xb}) - $signed({xa[31], xa});
    dyp = $signed({py[1][31], py[1]}) - $signed({py[0][31], py[0]});
    dxp = $signed({px[1][31], px[1]}) - $signed({px[0][31], px[0]});
    nxe = $signed({facet_r.normal_x[31], facet_r.normal_x});
    nye = $signed({facet_r.normal_y[31], facet_r.normal_y});
    sign_a = nxe[32] ^ dyp[32];
    sign_b = nye[32] ^ dxp[32];
    case (cmd.unit_op)
      OP_DIR_A: begin u_a = mag33(nxe); u_b = mag33(dyp); u_d = 33'd1; end
      OP_DIR_B: begin u_a = mag33(nye); u_b = mag33(dxp); u_d = 33'd1; end
      default:  begin u_a = mag33(num); u_b = mag33(dxi); u_d = mag33(den); end
    endcase
  end

  stmp_muldiv u_muldiv (
    .clk    (clk),
    .rst    (rst),
    .start  (cmd.unit_start),
    .div_en (cmd.unit_op == OP_INTERP),
    .a      (u_a),
    .b      (u_b),
    .d      (u_d),
    .done   (u_done),
    .prod   (u_prod),
    .quot   (u_quot)
  );

  always_comb begin
    interp_sum = dxi[32] ? $signed({xa[31], xa[31], xa}) - $signed({1'b0, u_quot})
                         : $signed({xa[31], xa[31], xa}) + $signed({1'b0, u_quot});
    if (is_v) pt_val = cmd.axis ? vy[vi] : vx[vi];
    else      pt_val = interp_sum[31:0];
    prod_b_s = sign_b ? -$signed({1'b0, u_prod}) : $signed({1'b0, u_prod});
  end

  // edge store compare and control
  always_comb begin
    full  = count == CW'(EDGE_DEPTH);
    match = (rd_entry.sx == px[0] && rd_entry.sy == py[0] &&
             rd_entry.ex == px[1] && rd_entry.ey == py[1]) ||
            (rd_entry.sx == px[1] && rd_entry.sy == py[1] &&
             rd_entry.ex == px[0] && rd_entry.ey == py[0]);
    do_append   = cmd.append && !found && !full;
    cancel_we   = (cmd.scan_cmp && match) || do_append;
    cancel_addr = cmd.scan_cmp ? idx[AW-1:0] : count[AW-1:0];
  end

  // result assembly
  always_comb begin
    out_free = !seg_valid || !seg_stall;
    push     = (cmd.produce || cmd.push_last) && hold_valid;
    if (cmd.produce_stored) begin
      new_seg.start_x       = rd_entry.sx;
      new_seg.start_y       = rd_entry.sy;
      new_seg.end_x         = rd_entry.ex;
      new_seg.end_y         = rd_entry.ey;
      new_seg.reversed      = rd_entry.rev;
      new_seg.in_plane_edge = 1'b1;
    end else begin
      new_seg.start_x       = px[0];
      new_seg.start_y       = py[0];
      new_seg.end_x         = px[1];
      new_seg.end_y         = py[1];
      new_seg.reversed      = rev;
      new_seg.in_plane_edge = 1'b0;
    end
    new_seg.store_overflow = ovf;
    new_seg.last_segment   = 1'b0;
    push_data              = hold;
    push_data.last_segment = cmd.push_last && facet_r.last_triangle;
  end

  // memories
  always_ff @(posedge clk) begin
    if (do_append) mem_entry[count[AW-1:0]] <= '{px[0], py[0], px[1], py[1], rev};
    if (cancel_we) mem_cancel[cancel_addr] <= cmd.scan_cmp;
    if (cmd.mem_rd) begin
      rd_entry  <= mem_entry[idx[AW-1:0]];
      rd_cancel <= mem_cancel[idx[AW-1:0]];
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.take) facet_r <= facet;
    if (cmd.load_edge) begin
      px[0] <= c2 ? vx[2] : vx[0];
      py[0] <= c2 ? vy[2] : vy[0];
      px[1] <= c1 ? vx[2] : vx[1];
      py[1] <= c1 ? vy[2] : vy[1];
    end
    if (cmd.write_pt) begin
      if (cmd.axis) py[cmd.slot] <= pt_val;
      else          px[cmd.slot] <= pt_val;
    end
    if (cmd.latch_a) prod_a <= sign_a ? -$signed({1'b0, u_prod}) : $signed({1'b0, u_prod});
    if (cmd.latch_rev) rev <= prod_a < prod_b_s;
    if (cmd.produce) hold <= new_seg;
    if (push) seg <= push_data;
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      height     <= '0;
      count      <= '0;
      idx        <= '0;
      found      <= 1'b0;
      ovf        <= 1'b0;
      hold_valid <= 1'b0;
      seg_valid  <= 1'b0;
    end else begin
      if (slice_height_we) height <= slice_height_data;
      if (cmd.idx_clear) begin
        idx   <= '0;
        found <= 1'b0;
      end else if (cmd.idx_inc) begin
        idx <= idx + CW'(1);
      end
      if (cmd.scan_cmp && match) found <= 1'b1;
      if (do_append) count <= count + CW'(1);
      if (cmd.append && !found && full) ovf <= 1'b1;
      if (cmd.clear_slice && facet_r.last_triangle) begin
        count <= '0;
        ovf   <= 1'b0;
      end
      if (cmd.produce)        hold_valid <= 1'b1;
      else if (cmd.push_last) hold_valid <= 1'b0;
      if (push)               seg_valid <= 1'b1;
      else if (!seg_stall)    seg_valid <= 1'b0;
    end
  end

  always_comb begin
    status.is_cross     = !(ge || le);
    status.is_edge      = !flat && (c0 || c1 || c2);
    status.pt_vertex    = is_v;
    status.unit_done    = u_done;
    status.idx_lt_count = idx < count;
    status.rd_cancelled = rd_cancel;
    status.produce_ok   = !hold_valid || out_free;
    status.hold_valid   = hold_valid;
    status.out_free     = out_free;
    status.last_tri     = facet_r.last_triangle;
  end

endmodule

`default_nettype wire

// File: hw/rtl/stmp_ctrl.sv
// controller state machine for the triangle mesh plane slicer
// depends on stmp_pkg
`default_nettype none

module stmp_ctrl (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   facet_valid,
  output logic                        facet_stall,
  input  wire stmp_pkg::stmp_status_t status,
  output stmp_pkg::stmp_cmd_t         cmd
);
  import stmp_pkg::*;

  ctrl_state_t state, state_next;
  logic [1:0]  job;

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:   if (facet_valid) state_next = S_CLASS;
      S_CLASS: begin
        if (status.is_cross)     state_next = S_PT_START;
        else if (status.is_edge) state_next = S_DIR_A;
        else                     state_next = S_FINISH;
      end
      S_PT_START:   state_next = status.pt_vertex ? S_PT_WR : S_PT_WAIT;
      S_PT_WAIT:    if (status.unit_done) state_next = S_PT_WR;
      S_PT_WR:      state_next = (job == 2'd3) ? S_DIR_A : S_PT_START;
      S_DIR_A:      state_next = S_DIR_A_WAIT;
      S_DIR_A_WAIT: if (status.unit_done) state_next = S_DIR_B;
      S_DIR_B:      state_next = S_DIR_B_WAIT;
      S_DIR_B_WAIT: if (status.unit_done) state_next = S_BRANCH;
      S_BRANCH:     state_next = status.is_cross ? S_PRODUCE : S_SCAN_RD;
      S_PRODUCE:    if (status.produce_ok) state_next = S_FINISH;
      S_SCAN_RD:    state_next = status.idx_lt_count ? S_SCAN_CMP : S_SCAN_END;
      S_SCAN_CMP:   state_next = S_SCAN_RD;
      S_SCAN_END:   state_next = S_FINISH;
      S_FINISH:     state_next = status.last_tri ? S_FL_RD : S_DRAIN;
      S_FL_RD:      state_next = status.idx_lt_count ? S_FL_CHK : S_DRAIN;
      S_FL_CHK:     if (status.rd_cancelled || status.produce_ok) state_next = S_FL_RD;
      S_DRAIN:      if (!status.hold_valid || status.out_free) state_next = S_IDLE;
      default:      state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd         = '0;
    cmd.unit_op = OP_INTERP;
    cmd.slot    = job[1];
    cmd.axis    = job[0];
    facet_stall = state != S_IDLE;
    case (state)
      S_IDLE:     cmd.take = facet_valid;
      S_CLASS:    cmd.load_edge = !status.is_cross && status.is_edge;
      S_PT_START: cmd.unit_start = !status.pt_vertex;
      S_PT_WR:    cmd.write_pt = 1'b1;
      S_DIR_A: begin
        cmd.unit_start = 1'b1;
        cmd.unit_op    = OP_DIR_A;
      end
      S_DIR_A_WAIT: cmd.latch_a = status.unit_done;
      S_DIR_B: begin
        cmd.unit_start = 1'b1;
        cmd.unit_op    = OP_DIR_B;
      end
      S_DIR_B_WAIT: cmd.latch_rev = status.unit_done;
      S_BRANCH:     cmd.idx_clear = !status.is_cross;
      S_PRODUCE:    cmd.produce = status.produce_ok;
      S_SCAN_RD:    cmd.mem_rd = status.idx_lt_count;
      S_SCAN_CMP: begin
        cmd.scan_cmp = 1'b1;
        cmd.idx_inc  = 1'b1;
      end
      S_SCAN_END:   cmd.append = 1'b1;
      S_FINISH:     cmd.idx_clear = status.last_tri;
      S_FL_RD:      cmd.mem_rd = status.idx_lt_count;
      S_FL_CHK: begin
        cmd.produce        = !status.rd_cancelled && status.produce_ok;
        cmd.produce_stored = 1'b1;
        cmd.idx_inc        = status.rd_cancelled || status.produce_ok;
      end
      S_DRAIN: begin
        cmd.push_last   = status.hold_valid && status.out_free;
        cmd.clear_slice = !status.hold_valid || status.out_free;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      job   <= '0;
    end else begin
      state <= state_next;
      if (state == S_CLASS)     job <= '0;
      else if (state == S_PT_WR) job <= job + 2'd1;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/slice_triangle_mesh_plane.sv
// top level of the triangle mesh plane slicer
// depends on stmp_pkg, stmp_ctrl, stmp_datapath (with stmp_muldiv)
`default_nettype none

// Cuts mesh triangles (Q16.16) against the plane z = slice_height and
// returns segment transactions. A crossing triangle yields one segment whose
// endpoints are interpolated edge crossings or a vertex on the plane; a
// triangle with one edge in the plane and the third vertex above puts that
// edge in an edge store of EDGE_DEPTH entries, where a repeat of the same
// edge (either orientation) cancels it. After the triangle marked last, the
// surviving stored edges follow, and the final result of the slice carries
// last_segment. One triangle is worked at a time. All interpolation and the
// direction test run on one bit-serial multiply-divide unit; a crossing
// triangle needs up to four interpolations plus two direction products, an
// in-plane edge two direction products and a search of the stored edges.
// The flush on the last triangle reads every stored edge. The block accepts
// the next triangle while a finished result still waits in the output
// register.

module slice_triangle_mesh_plane #(
  parameter int EDGE_DEPTH = stmp_pkg::EDGE_DEPTH_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  // configuration
  input  wire logic               slice_height_we,
  input  wire logic signed [31:0] slice_height_data,
  // triangle transactions
  input  wire logic               facet_valid,
  output logic                    facet_stall,
  input  wire stmp_pkg::facet_t   facet,
  // segment transactions
  output logic                    seg_valid,
  input  wire logic               seg_stall,
  output stmp_pkg::seg_t          seg
);
  import stmp_pkg::*;

  // command and status between sequencer and datapath
  stmp_cmd_t    cmd;
  stmp_status_t status;

  stmp_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .facet_valid (facet_valid),
    .facet_stall (facet_stall),
    .status      (status),
    .cmd         (cmd)
  );

  // datapath holds the plane height, the edge store and the output register
  stmp_datapath #(
    .EDGE_DEPTH (EDGE_DEPTH)
  ) u_dp (
    .clk               (clk),
    .rst               (rst),
    .slice_height_we   (slice_height_we),
    .slice_height_data (slice_height_data),
    .facet             (facet),
    .seg               (seg),
    .seg_valid         (seg_valid),
    .seg_stall         (seg_stall),
    .cmd               (cmd),
    .status            (status)
  );

endmodule

`default_nettype wire

// File: hw/rtl/stmp_checker.sv
// port-level checks for slice_triangle_mesh_plane, bound to the top level
// depends on stmp_pkg and slice_triangle_mesh_plane_macros.svh
`default_nettype none

`include "slice_triangle_mesh_plane_macros.svh"

module stmp_checker (
  input wire logic           clk,
  input wire logic           rst,
  input wire logic           facet_valid,
  input wire logic           facet_stall,
  input wire logic           seg_valid,
  input wire logic           seg_stall,
  input wire stmp_pkg::seg_t seg
);
  import stmp_pkg::*;

  // one triangle in work at a time
  `STMP_ASSERT_NEXT(a_busy_after_take, facet_valid && !facet_stall, facet_stall, "no stall after take")

  // a stalled result holds
  `STMP_ASSERT_NEXT(a_seg_hold, seg_valid && seg_stall, seg_valid && $stable(seg), "result changed under stall")

  // output register comes out of reset empty
  `STMP_ASSERT_SAME(a_reset_empty, $past(rst), !seg_valid, "result right after reset")

endmodule

bind slice_triangle_mesh_plane stmp_checker u_stmp_checker (.*);

`default_nettype wire
